### design/grid_bfs_path_finder_macros.svh
// assertion macros for the grid path finder top level
`ifndef GRID_BFS_PATH_FINDER_MACROS_SVH
`define GRID_BFS_PATH_FINDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define GBPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GBPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/gbpf_pkg.sv
// package with field widths, codes and constants of the grid path finder
`timescale 1ns / 1ps
package gbpf_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int COL_W    = 5;
  localparam int ROW_W    = 4;
  localparam int IDX_W    = 9;
  localparam int LEN_W    = 10;
  localparam int COLS_CFG_W = 6;
  localparam int ROWS_CFG_W = 5;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;
  // width for grid dimensions up to 256
  localparam int DIM_W    = 9;

  // function codes
  localparam logic [FUNC_W-1:0] FN_WALL   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 1'b1;

  // neighbor directions, in probe order
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [DIM_W-1:0]  dim_t;

endpackage

### design/gbpf_if.sv
// valid/ready channel interfaces for request and result items
`timescale 1ns / 1ps
interface gbpf_in_if;
  import gbpf_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  col_t  cell_col;
  row_t  cell_row;
  col_t  goal_col;
  row_t  goal_row;
  idx_t  path_index;
  modport source (output valid, func, cell_col, cell_row, goal_col, goal_row, path_index,
                  input ready);
  modport sink (input valid, func, cell_col, cell_row, goal_col, goal_row, path_index,
                output ready);
endinterface

interface gbpf_out_if;
  import gbpf_pkg::*;
  logic valid;
  logic ready;
  logic accepted;
  len_t path_length;
  col_t path_col;
  row_t path_row;
  modport source (output valid, accepted, path_length, path_col, path_row, input ready);
  modport sink (input valid, accepted, path_length, path_col, path_row, output ready);
endinterface

### design/gbpf_step_unit.sv
// shared neighbor step unit: moves a cell one step and checks grid bounds
`timescale 1ns / 1ps
module gbpf_step_unit #(
  parameter int CLW = 5,
  parameter int RW  = 4
) (
  input  logic [CLW-1:0]       col,
  input  logic [RW-1:0]        row,
  input  logic [1:0]           dir,
  input  logic                 back,
  input  gbpf_pkg::dim_t       eff_cols,
  input  gbpf_pkg::dim_t       eff_rows,
  output logic [CLW-1:0]       ncol,
  output logic [RW-1:0]        nrow,
  output logic                 ok
);
  import gbpf_pkg::*;

  logic [1:0] dir_e;

  // stepping back flips down/up and right/left
  assign dir_e = dir ^ {1'b0, back};

  always_comb begin
    ncol = col;
    nrow = row;
    ok   = 1'b0;
    case (dir_e)
      DIR_DOWN: begin
        nrow = row + RW'(1);
        ok   = (DIM_W'(row) + DIM_W'(1)) < eff_rows;
      end
      DIR_UP: begin
        nrow = row - RW'(1);
        ok   = (row != '0);
      end
      DIR_RIGHT: begin
        ncol = col + CLW'(1);
        ok   = (DIM_W'(col) + DIM_W'(1)) < eff_cols;
      end
      DIR_LEFT: begin
        ncol = col - CLW'(1);
        ok   = (col != '0);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

### design/grid_bfs_path_finder.sv
// top level: obstacle map, breadth-first search sequencer and path store
//
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid/ready         | func, cell/goal col+row, path_index
//  out_ch   | out | valid/ready         | accepted, path_length, path_col, path_row
//  cfg_*    | in  | cfg_we only         | cfg_index, cfg_wdata
//
// after reset a clearing pass over every cell address empties the obstacle
// and visited maps; no item is taken meanwhile.
// search: clears the visited map, probes the neighbors of every dequeued cell
// but the goal, and then traces the path back cell by cell; the single read
// port of each map memory sets the probe rate.
// a finished result waits in the output register; the next item waits only
// while that register is still full at the end of its own work.
`timescale 1ns / 1ps
module grid_bfs_path_finder #(
  parameter int MAX_COLUMNS = 32,
  parameter int MAX_ROWS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gbpf_in_if.sink                       in_ch,
  gbpf_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [gbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gbpf_pkg::*;
  `include "grid_bfs_path_finder_macros.svh"

  localparam int CLW   = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = CLW + RW;
  localparam int DEPTH = 1 << CW;

  // sequencer states
  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VCLR  = 4'd2;
  localparam logic [3:0] S_RDS   = 4'd3;
  localparam logic [3:0] S_RDG   = 4'd4;
  localparam logic [3:0] S_CHKSG = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_CUR   = 4'd7;
  localparam logic [3:0] S_PROBE = 4'd8;
  localparam logic [3:0] S_CHECK = 4'd9;
  localparam logic [3:0] S_TWR   = 4'd10;
  localparam logic [3:0] S_TSTEP = 4'd11;
  localparam logic [3:0] S_PRD   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  // control registers
  logic [3:0]              state_r, state_nxt;
  logic [CW-1:0]           clr_r, clr_nxt;
  logic [CW:0]             head_r, head_nxt;
  logic [CW:0]             tail_r, tail_nxt;
  logic [CW:0]             len_r, len_nxt;
  logic [CW:0]             stored_r, stored_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [COLS_CFG_W-1:0]   cols_r;
  logic [ROWS_CFG_W-1:0]   rows_r;

  // payload registers
  logic [CW-1:0]           s_r, s_nxt;
  logic [CW-1:0]           g_r, g_nxt;
  logic [CW-1:0]           cur_r, cur_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [CW-1:0]           p_r, p_nxt;
  logic [1:0]              d_r, d_nxt;
  logic                    obs_s_r, obs_s_nxt;
  logic                    res_acc_r, res_acc_nxt;
  col_t                    res_col_r, res_col_nxt;
  row_t                    res_row_r, res_row_nxt;
  logic                    out_acc_r, out_acc_nxt;
  len_t                    out_len_r, out_len_nxt;
  col_t                    out_col_r, out_col_nxt;
  row_t                    out_row_r, out_row_nxt;

  // memories
  logic                    obs_mem  [DEPTH];
  logic                    vis_mem  [DEPTH];
  logic [1:0]              dir_mem  [DEPTH];
  logic [CW-1:0]           q_mem    [DEPTH];
  logic [CW-1:0]           path_mem [DEPTH];

  logic                    obs_we, vis_we, dir_we, q_we, path_we;
  logic                    obs_wd, vis_wd;
  logic [CW-1:0]           obs_wa, vis_wa, dir_wa, q_wa, path_wa;
  logic [CW-1:0]           q_wd, path_wd;
  logic [1:0]              dir_wd;
  logic [CW-1:0]           obs_ra, vis_ra, dir_ra, q_ra, path_ra;
  logic                    obs_rd, vis_rd;
  logic [1:0]              dir_rd;
  logic [CW-1:0]           q_rd, path_rd;

  // grid size and input decode
  dim_t                    eff_cols, eff_rows;
  logic                    start_ok, goal_ok, idx_ok;
  logic [CW-1:0]           start_addr, goal_addr;
  logic [CW:0]             rd_pos;

  // step unit hookup
  logic [CLW-1:0]          st_col, st_ncol;
  logic [RW-1:0]           st_row, st_nrow;
  logic [1:0]              st_dir;
  logic                    st_back, st_ok;
  logic [CW-1:0]           st_addr;

  assign eff_cols = (DIM_W'(cols_r) > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS)
                                                           : DIM_W'(cols_r);
  assign eff_rows = (DIM_W'(rows_r) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                        : DIM_W'(rows_r);

  assign start_ok = (DIM_W'(in_ch.cell_col) < eff_cols) && (DIM_W'(in_ch.cell_row) < eff_rows);
  assign goal_ok  = (DIM_W'(in_ch.goal_col) < eff_cols) && (DIM_W'(in_ch.goal_row) < eff_rows);
  assign start_addr = {RW'(in_ch.cell_row), CLW'(in_ch.cell_col)};
  assign goal_addr  = {RW'(in_ch.goal_row), CLW'(in_ch.goal_col)};
  assign idx_ok   = (32'(in_ch.path_index) < 32'(stored_r));
  // path is stored goal first, so index i sits at length-1-i
  assign rd_pos   = stored_r - (CW+1)'(in_ch.path_index) - (CW+1)'(1);

  // one step unit serves forward probes and the trace back
  assign st_back = (state_r == S_TSTEP);
  assign st_col  = st_back ? p_r[CLW-1:0] : cur_r[CLW-1:0];
  assign st_row  = st_back ? p_r[CW-1:CLW] : cur_r[CW-1:CLW];
  assign st_dir  = st_back ? dir_rd : d_r;
  assign st_addr = {st_nrow, st_ncol};

  gbpf_step_unit #(.CLW(CLW), .RW(RW)) u_step (
    .col      (st_col),
    .row      (st_row),
    .dir      (st_dir),
    .back     (st_back),
    .eff_cols (eff_cols),
    .eff_rows (eff_rows),
    .ncol     (st_ncol),
    .nrow     (st_nrow),
    .ok       (st_ok)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_acc_r;
  assign out_ch.path_length = out_len_r;
  assign out_ch.path_col    = out_col_r;
  assign out_ch.path_row    = out_row_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    stored_nxt  = stored_r;
    s_nxt       = s_r;
    g_nxt       = g_r;
    cur_nxt     = cur_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    d_nxt       = d_r;
    obs_s_nxt   = obs_s_r;
    res_acc_nxt = res_acc_r;
    res_col_nxt = res_col_r;
    res_row_nxt = res_row_r;
    out_acc_nxt = out_acc_r;
    out_len_nxt = out_len_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    obs_we = 1'b0;  obs_wa = '0;  obs_wd = 1'b0;  obs_ra = '0;
    vis_we = 1'b0;  vis_wa = '0;  vis_wd = 1'b0;  vis_ra = '0;
    dir_we = 1'b0;  dir_wa = '0;  dir_wd = '0;    dir_ra = '0;
    q_we   = 1'b0;  q_wa   = '0;  q_wd   = '0;    q_ra   = '0;
    path_we = 1'b0; path_wa = '0; path_wd = '0;   path_ra = '0;
    case (state_r)
      S_INIT: begin
        obs_we = 1'b1;
        obs_wa = clr_r;
        vis_we = 1'b1;
        vis_wa = clr_r;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          res_acc_nxt = 1'b0;
          res_col_nxt = '0;
          res_row_nxt = '0;
          s_nxt = start_addr;
          g_nxt = goal_addr;
          state_nxt = S_FIN;
          case (in_ch.func)
            FN_WALL: begin
              if (start_ok) begin
                obs_we = 1'b1;
                obs_wa = start_addr;
                obs_wd = 1'b1;
                res_acc_nxt = 1'b1;
              end
            end
            FN_SEARCH: begin
              if (start_ok && goal_ok) begin
                clr_nxt = '0;
                state_nxt = S_VCLR;
              end else begin
                stored_nxt = '0;
              end
            end
            FN_READ: begin
              if (idx_ok) begin
                path_ra = rd_pos[CW-1:0];
                res_acc_nxt = 1'b1;
                state_nxt = S_PRD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      // clear visited marks
      S_VCLR: begin
        vis_we = 1'b1;
        vis_wa = clr_r;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == '1) begin
          state_nxt = S_RDS;
        end
      end
      S_RDS: begin
        obs_ra = s_r;
        state_nxt = S_RDG;
      end
      S_RDG: begin
        obs_ra = g_r;
        obs_s_nxt = obs_rd;
        state_nxt = S_CHKSG;
      end
      // blocked start or goal gives no path, else seed the queue
      S_CHKSG: begin
        if (obs_s_r || obs_rd) begin
          stored_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          vis_we = 1'b1;
          vis_wa = s_r;
          vis_wd = 1'b1;
          q_we = 1'b1;
          q_wa = '0;
          q_wd = s_r;
          head_nxt = '0;
          tail_nxt = (CW+1)'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          stored_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          q_ra = head_r[CW-1:0];
          head_nxt = head_r + (CW+1)'(1);
          state_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cur_nxt = q_rd;
        if (q_rd == g_r) begin
          p_nxt = g_r;
          len_nxt = '0;
          state_nxt = S_TWR;
        end else begin
          d_nxt = DIR_DOWN;
          state_nxt = S_PROBE;
        end
      end
      // neighbor in grid: fetch its wall and visited bits
      S_PROBE: begin
        if (st_ok) begin
          n_nxt = st_addr;
          obs_ra = st_addr;
          vis_ra = st_addr;
          state_nxt = S_CHECK;
        end else if (d_r == DIR_LEFT) begin
          state_nxt = S_POP;
        end else begin
          d_nxt = d_r + 2'd1;
        end
      end
      S_CHECK: begin
        if (!obs_rd && !vis_rd && !tail_r[CW]) begin
          vis_we = 1'b1;
          vis_wa = n_r;
          vis_wd = 1'b1;
          dir_we = 1'b1;
          dir_wa = n_r;
          dir_wd = d_r;
          q_we = 1'b1;
          q_wa = tail_r[CW-1:0];
          q_wd = n_r;
          tail_nxt = tail_r + (CW+1)'(1);
        end
        if (d_r == DIR_LEFT) begin
          state_nxt = S_POP;
        end else begin
          d_nxt = d_r + 2'd1;
          state_nxt = S_PROBE;
        end
      end
      // trace back from goal, storing cells goal first
      S_TWR: begin
        path_we = 1'b1;
        path_wa = len_r[CW-1:0];
        path_wd = p_r;
        len_nxt = len_r + (CW+1)'(1);
        if (p_r == s_r) begin
          stored_nxt = len_r + (CW+1)'(1);
          res_acc_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          dir_ra = p_r;
          state_nxt = S_TSTEP;
        end
      end
      S_TSTEP: begin
        p_nxt = st_addr;
        state_nxt = S_TWR;
      end
      S_PRD: begin
        res_col_nxt = COL_W'(path_rd[CLW-1:0]);
        res_row_nxt = ROW_W'(path_rd[CW-1:CLW]);
        state_nxt = S_FIN;
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt = res_acc_r;
          out_len_nxt = LEN_W'(stored_r);
          out_col_nxt = res_col_r;
          out_row_nxt = res_row_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
      cols_r      <= COLS_CFG_W'(21);
      rows_r      <= ROWS_CFG_W'(12);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      len_r       <= len_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_COLS) begin
          cols_r <= cfg_wdata;
        end else begin
          rows_r <= cfg_wdata[ROWS_CFG_W-1:0];
        end
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    g_r       <= g_nxt;
    cur_r     <= cur_nxt;
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    d_r       <= d_nxt;
    obs_s_r   <= obs_s_nxt;
    res_acc_r <= res_acc_nxt;
    res_col_r <= res_col_nxt;
    res_row_r <= res_row_nxt;
    out_acc_r <= out_acc_nxt;
    out_len_r <= out_len_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
  end

  // memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (obs_we) begin
      obs_mem[obs_wa] <= obs_wd;
    end
    obs_rd <= obs_mem[obs_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    dir_rd <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_rd <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_wa] <= path_wd;
    end
    path_rd <= path_mem[path_ra];
  end

  // queue head never passes the tail
  `GBPF_ASSERT_NOW(a_head_le_tail, (state_r == S_POP), (head_r <= tail_r), "queue head past tail")
  // stored path never longer than the grid
  `GBPF_ASSERT_NOW(a_len_bound, 1'b1, (stored_r <= (CW+1)'(DEPTH)), "stored path too long")
  // a new result appears only out of the finish state
  `GBPF_ASSERT_NEXT(a_load_from_fin, (!out_valid_r && state_r != S_FIN), !out_valid_r,
                    "result loaded outside finish")
  // a found path always ends at the start cell
  `GBPF_ASSERT_NEXT(a_trace_done, (state_r == S_TWR && p_r == s_r),
                    (state_r == S_FIN && res_acc_r), "trace did not finish at start")

endmodule
